// File: hdl/log_record_deframer_crc32c_check_macros.svh
// Assertion macros shared by the record deframer RTL
`ifndef LOG_RECORD_DEFRAMER_CRC32C_CHECK_MACROS_SVH
`define LOG_RECORD_DEFRAMER_CRC32C_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LRDC_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lrdc assertion failed");

// Next-cycle implication, disabled during reset
`define LRDC_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lrdc assertion failed");

`endif

// File: hdl/lrdc_pkg.sv
// Types and constants for the CRC-32C checked record deframer
package lrdc_pkg;

  localparam int unsigned POS_W = 34;

  // Record layout offsets
  localparam logic [POS_W-1:0] CRC_OFS   = 34'd4;
  localparam logic [POS_W-1:0] FLAG_OFS  = 34'd12;
  localparam logic [POS_W-1:0] KLEN_OFS  = 34'd13;
  localparam logic [POS_W-1:0] VLEN_OFS  = 34'd17;
  localparam logic [POS_W-1:0] HDR_BYTES = 34'd21;
  localparam logic [POS_W-1:0] HDR_LAST  = 34'd20;

  // CRC-32C, reflected form
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Region codes
  localparam logic [1:0] RGN_HEADER = 2'd0;
  localparam logic [1:0] RGN_KEY    = 2'd1;
  localparam logic [1:0] RGN_VALUE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_PROGRESS  = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_NEED_MORE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  region;
    logic        record_end;
    logic [1:0]  status;
    logic [63:0] timestamp_out;
    logic [7:0]  flag_out;
    logic [31:0] key_length_out;
    logic [31:0] value_length_out;
  } out_item_t;

endpackage

// File: hdl/lrdc_crc_byte.sv
// One-byte CRC-32C update, bit-wise reflected form
module lrdc_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import lrdc_pkg::*;

  // Eight shift/xor steps over the byte
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// File: hdl/log_record_deframer_crc32c_check.sv
// Top level of the CRC-32C checked record deframer.
// Each input byte passes an input register and then a result register.
// Throughput: one byte per cycle unless the result side stalls; the byte-wise CRC update
// and the length compares sit between the input register and the result register.
// Reset (rst, synchronous): both stages empty, record state back to offset zero.
`include "log_record_deframer_crc32c_check_macros.svh"

module log_record_deframer_crc32c_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrdc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrdc_pkg::out_item_t out_data
);
  import lrdc_pkg::*;

  // Input stage
  logic     in_reg_valid;
  in_item_t in_reg;

  // Record state
  logic [POS_W-1:0] byte_position;
  logic [31:0]      running_crc;
  logic [31:0]      stored_checksum;
  logic [63:0]      timestamp_reg;
  logic [7:0]       flag_reg;
  logic [31:0]      key_length_reg;
  logic [31:0]      value_length_reg;

  logic [POS_W-1:0] byte_position_next;
  logic [31:0]      running_crc_next;
  logic [31:0]      stored_checksum_next;
  logic [63:0]      timestamp_reg_next;
  logic [7:0]       flag_reg_next;
  logic [31:0]      key_length_reg_next;
  logic [31:0]      value_length_reg_next;

  logic [31:0]      crc_upd;
  logic             finished;
  out_item_t        out_data_next;

  logic advance;
  logic take;

  // Pipeline control: result register frees when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign take     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  lrdc_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (in_reg.data_byte),
    .crc_out (crc_upd)
  );

  // Header parse, region tag and record end check
  always_comb begin
    logic [7:0]       b;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] key_end;
    logic [POS_W-1:0] final_pos;
    logic [2:0]       ts_idx;
    logic [1:0]       len_idx;

    b       = in_reg.data_byte;
    pos     = byte_position;
    ts_idx  = pos[2:0] - CRC_OFS[2:0];
    len_idx = pos[1:0] - KLEN_OFS[1:0];

    stored_checksum_next  = stored_checksum;
    running_crc_next      = running_crc;
    timestamp_reg_next    = timestamp_reg;
    flag_reg_next         = flag_reg;
    key_length_reg_next   = key_length_reg;
    value_length_reg_next = value_length_reg;

    // header fields assemble little-endian
    if (pos < CRC_OFS) begin
      stored_checksum_next[{pos[1:0], 3'b000} +: 8] =
        stored_checksum[{pos[1:0], 3'b000} +: 8] | b;
    end else begin
      running_crc_next = crc_upd;
      priority if (pos < FLAG_OFS) begin
        timestamp_reg_next[{ts_idx, 3'b000} +: 8] =
          timestamp_reg[{ts_idx, 3'b000} +: 8] | b;
      end else if (pos == FLAG_OFS) begin
        flag_reg_next = b;
      end else if (pos < VLEN_OFS) begin
        key_length_reg_next[{len_idx, 3'b000} +: 8] =
          key_length_reg[{len_idx, 3'b000} +: 8] | b;
      end else if (pos < HDR_BYTES) begin
        value_length_reg_next[{len_idx, 3'b000} +: 8] =
          value_length_reg[{len_idx, 3'b000} +: 8] | b;
      end else begin
        // payload byte: no header field changes
      end
    end

    key_end   = HDR_BYTES + {2'b00, key_length_reg_next};
    final_pos = HDR_LAST + {2'b00, key_length_reg_next} + {2'b00, value_length_reg_next};

    out_data_next.byte_out   = b;
    out_data_next.region     = RGN_HEADER;
    out_data_next.record_end = 1'b0;
    out_data_next.status     = ST_PROGRESS;
    finished                 = 1'b0;

    if (pos >= HDR_BYTES) begin
      out_data_next.region = (pos < key_end) ? RGN_KEY : RGN_VALUE;
    end

    // complete record wins over buffer end
    if (pos >= HDR_LAST && pos == final_pos) begin
      finished                 = 1'b1;
      out_data_next.record_end = 1'b1;
      out_data_next.status     = ((running_crc_next ^ CRC_INIT) == stored_checksum_next) ?
                                 ST_OK : ST_MISMATCH;
    end else if (in_reg.buffer_end) begin
      finished                 = 1'b1;
      out_data_next.record_end = 1'b1;
      out_data_next.status     = ST_NEED_MORE;
    end

    out_data_next.timestamp_out    = timestamp_reg_next;
    out_data_next.flag_out         = flag_reg_next;
    out_data_next.key_length_out   = key_length_reg_next;
    out_data_next.value_length_out = value_length_reg_next;

    byte_position_next = pos + 34'd1;
  end

  // Record state: cleared after every outcome
  always_ff @(posedge clk) begin
    if (rst || (take && finished)) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      stored_checksum  <= '0;
      timestamp_reg    <= '0;
      flag_reg         <= '0;
      key_length_reg   <= '0;
      value_length_reg <= '0;
    end else if (take) begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      stored_checksum  <= stored_checksum_next;
      timestamp_reg    <= timestamp_reg_next;
      flag_reg         <= flag_reg_next;
      key_length_reg   <= key_length_reg_next;
      value_length_reg <= value_length_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= out_data_next;
    end
  end

  // Checks
  `LRDC_ASSERT_NOW(a_end_has_status, clk, rst, out_valid, (out_data.record_end == 1'b1) == (out_data.status != ST_PROGRESS))
  `LRDC_ASSERT_NEXT(a_restart_after_end, clk, rst, take && finished, byte_position == '0)
  `LRDC_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall, in_reg_valid && out_valid)
  `LRDC_ASSERT_NOW(a_crc_idle_in_checksum, clk, rst, byte_position <= CRC_OFS, running_crc == CRC_INIT)

endmodule

// File: tb/tb_log_record_deframer_crc32c_check.sv
// Self-checking testbench for the CRC-32C checked record deframer: records, truncations, noise
module tb_log_record_deframer_crc32c_check;
  timeunit 1ns;
  timeprecision 1ps;

  import lrdc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  log_record_deframer_crc32c_check dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Tracks the record parse state and the tagged bytes still owed by the block
  class deframe_tracker;
    out_item_t        tagged_bytes_due[$];
    int unsigned      errors;
    int unsigned      results_seen;
    logic [POS_W-1:0] rec_pos;
    logic [31:0]      crc_acc;
    logic [31:0]      crc_stored;
    logic [63:0]      stamp;
    logic [7:0]       flg;
    logic [31:0]      key_len;
    logic [31:0]      val_len;

    function new();
      errors = 0;
      results_seen = 0;
      clear_record();
    endfunction

    function void clear_record();
      rec_pos    = '0;
      crc_acc    = CRC_INIT;
      crc_stored = '0;
      stamp      = '0;
      flg        = '0;
      key_len    = '0;
      val_len    = '0;
    endfunction

    // One byte of reflected CRC-32C
    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++)
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    // Advance the parse by one accepted byte and queue the tagged byte it yields
    function void take_byte(in_item_t it);
      out_item_t        r;
      logic [POS_W-1:0] at;
      logic [POS_W-1:0] last_at;
      logic [7:0]       b;
      int unsigned      sh;
      bit               closed;
      r      = '0;
      at     = rec_pos;
      b      = it.data_byte;
      sh     = 32'(at[4:0]);
      closed = 0;
      r.region = RGN_HEADER;
      r.status = ST_PROGRESS;

      // header fields, little-endian
      if (at < CRC_OFS) begin
        crc_stored |= 32'(b) << (8 * sh);
      end else begin
        crc_acc = crc_step(crc_acc, b);
        if (at < FLAG_OFS)
          stamp |= 64'(b) << (8 * (sh - 4));
        else if (at == FLAG_OFS)
          flg = b;
        else if (at < VLEN_OFS)
          key_len |= 32'(b) << (8 * (sh - 13));
        else if (at < HDR_BYTES)
          val_len |= 32'(b) << (8 * (sh - 17));
      end

      if (at >= HDR_BYTES)
        r.region = (at < HDR_BYTES + {2'b00, key_len}) ? RGN_KEY : RGN_VALUE;

      // record completion wins over buffer end
      if (at >= HDR_LAST) begin
        last_at = HDR_LAST + {2'b00, key_len} + {2'b00, val_len};
        if (at == last_at) begin
          closed   = 1;
          r.status = ((crc_acc ^ 32'hFFFF_FFFF) == crc_stored) ? ST_OK : ST_MISMATCH;
        end
      end
      if (!closed && it.buffer_end) begin
        closed   = 1;
        r.status = ST_NEED_MORE;
      end

      r.byte_out         = b;
      r.record_end       = closed;
      r.timestamp_out    = stamp;
      r.flag_out         = flg;
      r.key_length_out   = key_len;
      r.value_length_out = val_len;
      tagged_bytes_due.push_back(r);

      if (closed)
        clear_record();
      else
        rec_pos = rec_pos + 34'd1;
    endfunction

    function void note_error(string msg);
      if (errors < REPORT_MAX)
        $display("[%0t] %s", $time, msg);
      errors++;
    endfunction

    function void check_field(string fname, logic [63:0] got_v, logic [63:0] exp_v);
      if (got_v !== exp_v)
        note_error($sformatf("result %0d: %s expected %0h, got %0h",
                             results_seen, fname, exp_v, got_v));
    endfunction

    // Compare one result transfer with the oldest owed byte
    function void match_result(out_item_t got);
      out_item_t want;
      if (tagged_bytes_due.size() == 0) begin
        note_error($sformatf("unexpected result, byte %0h status %0d",
                             got.byte_out, got.status));
        return;
      end
      want = tagged_bytes_due.pop_front();
      check_field("byte_out", 64'(got.byte_out), 64'(want.byte_out));
      check_field("region", 64'(got.region), 64'(want.region));
      check_field("record_end", 64'(got.record_end), 64'(want.record_end));
      check_field("status", 64'(got.status), 64'(want.status));
      check_field("timestamp_out", got.timestamp_out, want.timestamp_out);
      check_field("flag_out", 64'(got.flag_out), 64'(want.flag_out));
      check_field("key_length_out", 64'(got.key_length_out), 64'(want.key_length_out));
      check_field("value_length_out", 64'(got.value_length_out),
                  64'(want.value_length_out));
      results_seen++;
    endfunction
  endclass

  deframe_tracker tracker;
  in_item_t       stim_q[$];

  // Build one record; cut >= 0 truncates it there with buffer end
  task automatic add_record(int unsigned klen, int unsigned vlen, logic [63:0] ts,
                            logic [7:0] fl, bit corrupt, int cut, bit end_on_last);
    logic [7:0]  rec[$];
    logic [31:0] crc;
    bit          be;
    for (int i = 0; i < 4; i++) rec.push_back(8'h00);
    for (int i = 0; i < 8; i++) rec.push_back(ts[8*i +: 8]);
    rec.push_back(fl);
    for (int i = 0; i < 4; i++) rec.push_back(8'(klen >> (8 * i)));
    for (int i = 0; i < 4; i++) rec.push_back(8'(vlen >> (8 * i)));
    for (int unsigned i = 0; i < klen + vlen; i++) rec.push_back(8'($urandom_range(255)));
    crc = CRC_INIT;
    for (int i = 4; i < rec.size(); i++) crc = deframe_tracker::crc_step(crc, rec[i]);
    crc = ~crc;
    if (corrupt) crc ^= 32'h1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) rec[i] = crc[8*i +: 8];
    for (int i = 0; i < rec.size(); i++) begin
      if (cut >= 0 && i > cut) break;
      be = (i == cut) || (end_on_last && i == rec.size() - 1);
      stim_q.push_back(in_item_t'{data_byte: rec[i], buffer_end: be});
    end
  endtask

  // Random bytes, buffer end at random and on the last one to resync the parse
  task automatic add_noise(int unsigned n);
    bit be;
    for (int unsigned i = 0; i < n; i++) begin
      be = (i == n - 1) || ($urandom_range(15) == 0);
      stim_q.push_back(in_item_t'{data_byte: 8'($urandom_range(255)), buffer_end: be});
    end
  endtask

  task automatic build_stimulus();
    int unsigned base;
    int unsigned roll;
    int unsigned klen;
    int unsigned vlen;
    // empty key and value, all-ones timestamp and flag, record end with buffer end
    add_record(0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, -1, 1);
    // truncated mid-timestamp: partly decoded header
    add_record(0, 0, {$urandom, $urandom}, 8'h00, 0, 5, 0);
    // buffer end on the very first byte
    stim_q.push_back(in_item_t'{data_byte: 8'h80, buffer_end: 1'b1});

    base = stim_q.size();
    while (stim_q.size() < base + RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      klen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      vlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (roll < 70)
        add_record(klen, vlen, {$urandom, $urandom}, 8'($urandom_range(255)),
                   $urandom_range(3) == 0, -1, $urandom_range(9) == 0);
      else if (roll < 85)
        add_record(klen, vlen, {$urandom, $urandom}, 8'($urandom_range(255)),
                   0, $urandom_range(0, 19 + klen + vlen), 0);
      else
        add_noise($urandom_range(1, 40));
    end
  endtask

  // Random idling outside a quiet window
  function automatic bit take_break(int unsigned n);
    return !(n >= 300 && n < 650) && ($urandom_range(99) < 38);
  endfunction

  // Send the stimulus, holding each payload while stalled
  task automatic drive_bytes();
    int unsigned sent = 0;
    while (sent < stim_q.size()) begin
      @(posedge clk);
      if (in_valid && !in_stall) sent++;
      if (!(in_valid && in_stall)) begin
        if (sent == stim_q.size() || take_break(sent)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= stim_q[sent];
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= (tracker != null) && take_break(tracker.results_seen);
    end
  end

  // Observe transfers on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.take_byte(in_data);
      if (out_valid && !out_stall) tracker.match_result(out_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("log_record_deframer_crc32c_check verification failed");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    tracker  = new();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    drive_bytes();
    while (tracker.tagged_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.tagged_bytes_due.size() == 0)
      $display("log_record_deframer_crc32c_check verification clean");
    else
      $display("log_record_deframer_crc32c_check verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lrdc_pkg.sv
hdl/lrdc_crc_byte.sv
hdl/log_record_deframer_crc32c_check.sv
tb/tb_log_record_deframer_crc32c_check.sv
